// ===== src/hsvwct_pkg.sv =====
package hsvwct_pkg;

    // Field widths fixed by the stream format
    localparam int PIX_W     = 10;
    localparam int HUE_W     = 8;
    localparam int CH_W      = 8;
    localparam int TOL_W     = 7;
    localparam int CEN_W     = 14;
    localparam int COUNT_W   = 21;
    localparam int SUM_W     = COUNT_W + PIX_W;
    localparam int CRD_W     = 15;
    localparam int SIZE_W    = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;

    localparam int CENTRE_MAX = 16383;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Default values of the top-level parameters
    localparam int DEF_IMG_WIDTH  = 1024;
    localparam int DEF_IMG_HEIGHT = 1024;
    localparam int DEF_HUE_RANGE  = 180;
    localparam int DEF_FRAC_BITS  = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HUE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_LOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_HIGH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_LOW       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_HIGH      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_HEIGHT    = 3'd7;

    // Controller to datapath commands
    typedef struct packed {
        logic load_en;     // load start centre, begin tracking
        logic pix_en;      // accumulate the accepted pixel
        logic empty_en;    // frame ended with no match
        logic div_start;   // load the centroid dividers
        logic div_step;    // one quotient bit per divider
        logic finish_en;   // write new centre and result
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic cfg_pend;    // window bounds not yet refreshed after a write
        logic active;
        logic count_zero;
        logic out_valid;
        logic div_done;
    } dp_stat_t;

endpackage

// ===== src/hsv_window_centroid_tracker_top.sv =====
// Channel   Dir  Beat contents
// s_*       in   tdata: pix_x, pix_y, hue, sat, val; tuser: operation; tlast: frame_end
// m_*       out  tdata: centre_x, centre_y, weight; tuser: tracking
// cfg_*     in   cfg_we, cfg_index, cfg_data; one register write per cycle with cfg_we
//
// Pixels stream one beat per clock while not stalled; a load beat or a configuration write stalls
// the input for the cycle after it. A frame end with matches stalls through the check state, the
// steps of the bit-serial centroid dividers, the finish and the window refresh.
// A frame end with no match stalls through the check and the window refresh.
// After reset the input is ready once the bounds state has passed; a waiting result lets
// the next frame stream; its frame end holds in the check state until the result is taken.
module hsv_window_centroid_tracker_top #(
    parameter int IMG_WIDTH  = hsvwct_pkg::DEF_IMG_WIDTH,
    parameter int IMG_HEIGHT = hsvwct_pkg::DEF_IMG_HEIGHT,
    parameter int HUE_RANGE  = hsvwct_pkg::DEF_HUE_RANGE,
    parameter int FRAC_BITS  = hsvwct_pkg::DEF_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hsvwct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hsvwct_pkg::CFG_W-1:0]     cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [47:0]                      s_tdata,  // pix_x, pix_y, hue, sat, val, pad
    input  logic                             s_tuser,  // operation
    input  logic                             s_tlast,  // frame_end
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [55:0]                      m_tdata,  // centre_x, centre_y, weight, pad
    output logic                             m_tuser   // tracking
);
    import hsvwct_pkg::*;

    ctrl_cmd_t          cmd;
    dp_stat_t           stat;
    logic [CEN_W-1:0]   centre_x, centre_y;
    logic [COUNT_W-1:0] weight;

    hsvwct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .operation (s_tuser),
        .frame_end (s_tlast),
        .s_tready  (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hsvwct_datapath #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT),
        .HUE_RANGE  (HUE_RANGE),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_x     (s_tdata[9:0]),
        .pix_y     (s_tdata[19:10]),
        .hue       (s_tdata[27:20]),
        .sat       (s_tdata[35:28]),
        .val       (s_tdata[43:36]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .out_valid (m_tvalid),
        .tracking  (m_tuser),
        .centre_x  (centre_x),
        .centre_y  (centre_y),
        .weight    (weight)
    );

    // Pack the result beat
    assign m_tdata = {7'b0, weight, centre_y, centre_x};

endmodule

// ===== src/hsvwct_ctrl.sv =====
module hsvwct_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   operation,
    input  logic                   frame_end,
    output logic                   s_tready,
    input  hsvwct_pkg::dp_stat_t   stat,
    output hsvwct_pkg::ctrl_cmd_t  cmd
);
    import hsvwct_pkg::*;

    typedef enum logic [3:0] {
        S_BOUNDS = 4'b0001,
        S_RUN    = 4'b0010,
        S_CHECK  = 4'b0100,
        S_DIV    = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign accept = s_tvalid && s_tready;

    // Sequence pixels, frame end check and the divide
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_BOUNDS:
            begin
                state_next = S_RUN;
            end
            S_RUN:
            begin
                s_tready = !stat.cfg_pend;
                if (accept)
                begin
                    if (operation)
                    begin
                        cmd.load_en = 1'b1;
                        state_next  = S_BOUNDS;
                    end
                    else if (stat.active)
                    begin
                        cmd.pix_en = 1'b1;
                        if (frame_end)
                        begin
                            state_next = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                // hold until the previous result has been taken
                if (!stat.out_valid)
                begin
                    if (stat.count_zero)
                    begin
                        cmd.empty_en = 1'b1;
                        state_next   = S_BOUNDS;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.finish_en = 1'b1;
                    state_next    = S_BOUNDS;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_BOUNDS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOUNDS;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/hsvwct_window.sv =====
module hsvwct_window #(
    parameter int LIMIT     = hsvwct_pkg::DEF_IMG_WIDTH,
    parameter int FRAC_BITS = hsvwct_pkg::DEF_FRAC_BITS
) (
    input  logic                          clk,
    input  logic [hsvwct_pkg::CEN_W-1:0]  centre,
    input  logic [hsvwct_pkg::SIZE_W-1:0] size,
    output logic [hsvwct_pkg::CRD_W-1:0]  lo,
    output logic [hsvwct_pkg::CRD_W-1:0]  hi
);
    import hsvwct_pkg::*;

    localparam int UNIT_SH = FRAC_BITS + 1;
    localparam int BW      = ((FRAC_BITS > 1) ? (FRAC_BITS + 14) : 15) + 2;
    localparam logic signed [BW-1:0] UNIT      = BW'(longint'(1) << UNIT_SH);
    localparam logic signed [BW-1:0] HALF_UNIT = BW'(longint'(1) << FRAC_BITS);
    localparam logic signed [BW-1:0] LIM       = BW'(longint'(LIMIT) << UNIT_SH);
    localparam logic signed [BW-1:0] LAST      = BW'(longint'(LIMIT - 1) << UNIT_SH);

    logic signed [BW-1:0] c2, half, a, b, a_rnd, b_rnd;
    logic [CRD_W-1:0]     lo_reg, lo_next, hi_reg, hi_next;

    // Corners at half-step precision, clamp, then round to whole pixels
    always_comb
    begin
        c2   = BW'({centre, 1'b0});
        half = BW'(size) << FRAC_BITS;
        a    = c2 - half;
        b    = c2 + half;
        if (a < 0)
        begin
            a = '0;
        end
        if (b >= LIM)
        begin
            b = LAST;
        end
        if (a > b)
        begin
            b = a + UNIT;
        end
        a_rnd   = a + HALF_UNIT;
        b_rnd   = b + HALF_UNIT;
        lo_next = a_rnd[UNIT_SH +: CRD_W];
        hi_next = b_rnd[UNIT_SH +: CRD_W];
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

// ===== src/hsvwct_datapath.sv =====
module hsvwct_datapath #(
    parameter int IMG_WIDTH  = hsvwct_pkg::DEF_IMG_WIDTH,
    parameter int IMG_HEIGHT = hsvwct_pkg::DEF_IMG_HEIGHT,
    parameter int HUE_RANGE  = hsvwct_pkg::DEF_HUE_RANGE,
    parameter int FRAC_BITS  = hsvwct_pkg::DEF_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hsvwct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hsvwct_pkg::CFG_W-1:0]     cfg_data,
    input  logic [hsvwct_pkg::PIX_W-1:0]     pix_x,
    input  logic [hsvwct_pkg::PIX_W-1:0]     pix_y,
    input  logic [hsvwct_pkg::HUE_W-1:0]     hue,
    input  logic [hsvwct_pkg::CH_W-1:0]      sat,
    input  logic [hsvwct_pkg::CH_W-1:0]      val,
    input  hsvwct_pkg::ctrl_cmd_t            cmd,
    output hsvwct_pkg::dp_stat_t             stat,
    input  logic                             m_tready,
    output logic                             out_valid,
    output logic                             tracking,
    output logic [hsvwct_pkg::CEN_W-1:0]     centre_x,
    output logic [hsvwct_pkg::CEN_W-1:0]     centre_y,
    output logic [hsvwct_pkg::COUNT_W-1:0]   weight
);
    import hsvwct_pkg::*;

    localparam int QW  = PIX_W + FRAC_BITS;
    localparam int NW  = SUM_W + FRAC_BITS;
    localparam int XW  = CRD_W + FRAC_BITS + 1;
    localparam int DCW = $clog2(QW + 1);
    localparam logic [8:0]    HR   = 9'(HUE_RANGE);
    localparam logic [XW-1:0] CMAX = XW'(CENTRE_MAX);

    // Configuration registers
    logic [HUE_W-1:0]  target_hue_reg;
    logic [TOL_W-1:0]  hue_tol_reg;
    logic [CH_W-1:0]   sat_low_reg, sat_high_reg, val_low_reg, val_high_reg;
    logic [SIZE_W-1:0] win_w_reg, win_h_reg;
    logic              cfg_pend_reg;

    // Tracking state
    logic [CEN_W-1:0]   cx_reg, cy_reg;
    logic               active_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [SUM_W-1:0]   sum_x_reg, sum_y_reg;

    // Divider lanes: index 0 is x, 1 is y
    logic [COUNT_W-1:0] rem_reg  [2];
    logic [QW-1:0]      quo_reg  [2];
    logic [COUNT_W-1:0] rem_next [2];
    logic [QW-1:0]      quo_next [2];
    logic [DCW-1:0]     dcnt_reg;

    // Result register
    logic               out_valid_reg;
    logic               out_trk_reg;
    logic [CEN_W-1:0]   out_cx_reg, out_cy_reg;
    logic [COUNT_W-1:0] out_wt_reg;

    logic [CRD_W-1:0] x1, x2, y1, y2;
    logic             in_win, colour_ok, hit;
    logic [HUE_W-1:0] hdiff;
    logic [8:0]       hdist, halt;
    logic [PIX_W-1:0] dx, dy;
    logic [NW-1:0]    num [2];
    logic [SUM_W-1:0] sum_sel [2];
    logic [COUNT_W:0] trial [2];
    logic             ge [2];
    logic [XW-1:0]    ncx, ncy, lcx, lcy;
    logic [CEN_W-1:0] ncx_sat, ncy_sat, lcx_sat, lcy_sat;

    hsvwct_window #(
        .LIMIT     (IMG_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_win_x (
        .clk    (clk),
        .centre (cx_reg),
        .size   (win_w_reg),
        .lo     (x1),
        .hi     (x2)
    );

    hsvwct_window #(
        .LIMIT     (IMG_HEIGHT),
        .FRAC_BITS (FRAC_BITS)
    ) u_win_y (
        .clk    (clk),
        .centre (cy_reg),
        .size   (win_h_reg),
        .lo     (y1),
        .hi     (y2)
    );

    // Window test and colour match for the pixel on the input
    always_comb
    begin
        in_win = (CRD_W'(pix_x) >= x1) && (CRD_W'(pix_x) < x2) &&
                 (CRD_W'(pix_y) >= y1) && (CRD_W'(pix_y) < y2);
        hdiff  = (hue > target_hue_reg) ? (hue - target_hue_reg) : (target_hue_reg - hue);
        hdist  = {1'b0, hdiff};
        halt   = HR - hdist;
        if ((hdist <= HR) && (halt < hdist))
        begin
            hdist = halt;
        end
        colour_ok = ({1'b0, hue} < HR) &&
                    (sat >= sat_low_reg) && (sat <= sat_high_reg) &&
                    (val >= val_low_reg) && (val <= val_high_reg) &&
                    (hdist <= {2'b00, hue_tol_reg});
        hit = in_win && colour_ok && (count_reg != COUNT_MAX);
        dx  = pix_x - x1[PIX_W-1:0];
        dy  = pix_y - y1[PIX_W-1:0];
    end

    // Divider numerators and one restoring step per lane
    always_comb
    begin
        sum_sel[0] = sum_x_reg;
        sum_sel[1] = sum_y_reg;
        for (int i = 0; i < 2; i++)
        begin
            num[i]      = (NW'(sum_sel[i]) << FRAC_BITS) + NW'(count_reg >> 1);
            trial[i]    = {rem_reg[i], quo_reg[i][QW-1]};
            ge[i]       = trial[i] >= {1'b0, count_reg};
            rem_next[i] = ge[i] ? COUNT_W'(trial[i] - {1'b0, count_reg})
                                : trial[i][COUNT_W-1:0];
            quo_next[i] = {quo_reg[i][QW-2:0], ge[i]};
        end
    end

    // New centre from origin plus quotient, and load centre, both saturated
    always_comb
    begin
        ncx     = (XW'(x1) << FRAC_BITS) + XW'(quo_reg[0]);
        ncy     = (XW'(y1) << FRAC_BITS) + XW'(quo_reg[1]);
        lcx     = XW'(pix_x) << FRAC_BITS;
        lcy     = XW'(pix_y) << FRAC_BITS;
        ncx_sat = (ncx > CMAX) ? CMAX[CEN_W-1:0] : ncx[CEN_W-1:0];
        ncy_sat = (ncy > CMAX) ? CMAX[CEN_W-1:0] : ncy[CEN_W-1:0];
        lcx_sat = (lcx > CMAX) ? CMAX[CEN_W-1:0] : lcx[CEN_W-1:0];
        lcy_sat = (lcy > CMAX) ? CMAX[CEN_W-1:0] : lcy[CEN_W-1:0];
    end

    // Configuration writes; flag a refresh of the window bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_hue_reg <= '0;
            hue_tol_reg    <= TOL_W'(10);
            sat_low_reg    <= '0;
            sat_high_reg   <= '1;
            val_low_reg    <= '0;
            val_high_reg   <= '1;
            win_w_reg      <= SIZE_W'(32);
            win_h_reg      <= SIZE_W'(32);
            cfg_pend_reg   <= 1'b0;
        end
        else
        begin
            cfg_pend_reg <= cfg_we;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TARGET_HUE:    target_hue_reg <= cfg_data[HUE_W-1:0];
                    CFG_HUE_TOLERANCE: hue_tol_reg    <= cfg_data[TOL_W-1:0];
                    CFG_SAT_LOW:       sat_low_reg    <= cfg_data[CH_W-1:0];
                    CFG_SAT_HIGH:      sat_high_reg   <= cfg_data[CH_W-1:0];
                    CFG_VAL_LOW:       val_low_reg    <= cfg_data[CH_W-1:0];
                    CFG_VAL_HIGH:      val_high_reg   <= cfg_data[CH_W-1:0];
                    CFG_WIN_WIDTH:     win_w_reg      <= cfg_data[SIZE_W-1:0];
                    CFG_WIN_HEIGHT:    win_h_reg      <= cfg_data[SIZE_W-1:0];
                    default:           target_hue_reg <= target_hue_reg;
                endcase
            end
        end
    end

    // Tracking state and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            active_reg <= 1'b0;
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
        end
        else if (cmd.load_en)
        begin
            cx_reg     <= lcx_sat;
            cy_reg     <= lcy_sat;
            active_reg <= 1'b1;
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
        end
        else if (cmd.pix_en)
        begin
            if (hit)
            begin
                count_reg <= count_reg + COUNT_W'(1);
                sum_x_reg <= sum_x_reg + SUM_W'(dx);
                sum_y_reg <= sum_y_reg + SUM_W'(dy);
            end
        end
        else if (cmd.empty_en)
        begin
            active_reg <= 1'b0;
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
        end
        else if (cmd.finish_en)
        begin
            cx_reg    <= ncx_sat;
            cy_reg    <= ncy_sat;
            count_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
    end

    // Step counter of the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            dcnt_reg <= DCW'(QW);
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg - DCW'(1);
        end
    end

    // Divider lanes: load numerator, then shift one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (cmd.div_start)
            begin
                rem_reg[i] <= num[i][NW-1:QW];
                quo_reg[i] <= num[i][QW-1:0];
            end
            else if (cmd.div_step)
            begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    // Result valid flag: set on frame end, drop when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.empty_en || cmd.finish_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.empty_en)
        begin
            out_trk_reg <= 1'b0;
            out_cx_reg  <= cx_reg;
            out_cy_reg  <= cy_reg;
            out_wt_reg  <= '0;
        end
        else if (cmd.finish_en)
        begin
            out_trk_reg <= 1'b1;
            out_cx_reg  <= ncx_sat;
            out_cy_reg  <= ncy_sat;
            out_wt_reg  <= count_reg;
        end
    end

    assign stat.cfg_pend   = cfg_pend_reg;
    assign stat.active     = active_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.out_valid  = out_valid_reg;
    assign stat.div_done   = (dcnt_reg == '0);

    assign out_valid = out_valid_reg;
    assign tracking  = out_trk_reg;
    assign centre_x  = out_cx_reg;
    assign centre_y  = out_cy_reg;
    assign weight    = out_wt_reg;

endmodule

// ===== test/tb_hsv_window_centroid_tracker_top.sv =====
module tb_hsv_window_centroid_tracker_top;

    import hsvwct_pkg::*;

    localparam int FRAC           = DEF_FRAC_BITS;
    localparam int IMG_W          = DEF_IMG_WIDTH;
    localparam int IMG_H          = DEF_IMG_HEIGHT;
    localparam int HUE_R          = DEF_HUE_RANGE;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRESSURE_HOLD  = 300;
    localparam int RANDOM_ITEMS   = 200;
    localparam int RANDOM_RESULTS = 12;
    localparam int MAX_PRINTS     = 100;
    localparam longint SUM_MASK   = (64'd1 << 40) - 1;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_LOAD  = 1'b1
    } op_e;

    typedef struct {
        op_e        op;
        logic [9:0] x;
        logic [9:0] y;
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        logic       last;
    } pixel_beat_t;

    typedef struct {
        logic        tracking;
        logic [13:0] cx;
        logic [13:0] cy;
        logic [20:0] weight;
    } centroid_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata   = '0;  // pix_x, pix_y, hue, sat, val, pad
    logic                 s_tuser   = 1'b0;  // operation
    logic                 s_tlast   = 1'b0;  // frame_end
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [55:0]          m_tdata;  // centre_x, centre_y, weight, pad
    logic                 m_tuser;  // tracking

    // Tracker state mirrored by the predictor
    int     reg_file [8] = '{0, 10, 0, 255, 0, 255, 32, 32};
    int     reg_width [8] = '{8, 7, 8, 8, 8, 8, 11, 11};
    int     trk_cx, trk_cy;
    bit     trk_active;
    longint trk_count, trk_sum_x, trk_sum_y;

    centroid_t centroid_q [$];

    int  mismatches;
    int  beats_used;
    int  loads_sent;
    int  results_expected;
    int  results_seen;
    int  results_lost;
    int  idle_cycles;
    bit  tx_idling = 1'b1;
    bit  rx_idling = 1'b1;
    int  rx_stall;
    int  rx_hold_req;
    centroid_t got_c, want_c;

    hsv_window_centroid_tracker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 clk = ~clk;

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else if (r < 99)
            return $urandom_range(8, 4);
        return $urandom_range(40, 15);
    endfunction

    // Window bounds along one axis in whole pixels, [lo, hi)
    function automatic void axis_window(input int centre, input int span, input int limit,
                                        output int lo, output int hi);
        int one_px, c2, half, a, b;
        one_px = 1 << (FRAC + 1);
        c2     = centre * 2;
        half   = span << FRAC;
        a      = c2 - half;
        b      = c2 + half;
        if (a < 0)
            a = 0;
        if (b >= limit * one_px)
            b = (limit - 1) * one_px;
        // keep the far corner past the near one
        if (a > b)
            b = a + one_px;
        lo = (a + one_px / 2) / one_px;
        hi = (b + one_px / 2) / one_px;
    endfunction

    function automatic int sat_centre(input longint v);
        return (v > CENTRE_MAX) ? CENTRE_MAX : int'(v);
    endfunction

    function automatic bit colour_ok(input int h, input int s, input int v);
        int tgt, diff, hue_gap;
        tgt = reg_file[CFG_TARGET_HUE];
        if (h >= HUE_R)
            return 1'b0;
        if (s < reg_file[CFG_SAT_LOW] || s > reg_file[CFG_SAT_HIGH])
            return 1'b0;
        if (v < reg_file[CFG_VAL_LOW] || v > reg_file[CFG_VAL_HIGH])
            return 1'b0;
        // circular hue distance
        diff    = (h > tgt) ? h - tgt : tgt - h;
        hue_gap = diff;
        if (diff <= HUE_R && HUE_R - diff < hue_gap)
            hue_gap = HUE_R - diff;
        return hue_gap <= reg_file[CFG_HUE_TOLERANCE];
    endfunction

    function automatic int centroid_coord(input int origin, input longint sum,
                                          input longint count);
        longint frac;
        frac = ((sum << FRAC) + count / 2) / count;
        return sat_centre((longint'(origin) << FRAC) + frac);
    endfunction

    // Advance the tracker by one accepted beat, queue the centroid on frame end
    task automatic update_centroid(input pixel_beat_t b);
        int xl, xh, yl, yh;
        centroid_t res;
        if (b.op == OP_LOAD)
        begin
            trk_cx     = sat_centre(longint'(b.x) << FRAC);
            trk_cy     = sat_centre(longint'(b.y) << FRAC);
            trk_active = 1'b1;
            trk_count  = 0;
            trk_sum_x  = 0;
            trk_sum_y  = 0;
            beats_used++;
            loads_sent++;
            return;
        end
        if (!trk_active)
            return;
        beats_used++;
        axis_window(trk_cx, reg_file[CFG_WIN_WIDTH], IMG_W, xl, xh);
        axis_window(trk_cy, reg_file[CFG_WIN_HEIGHT], IMG_H, yl, yh);
        if (int'(b.x) >= xl && int'(b.x) < xh && int'(b.y) >= yl && int'(b.y) < yh &&
            colour_ok(int'(b.hue), int'(b.sat), int'(b.val)) && trk_count < COUNT_MAX)
        begin
            trk_count++;
            trk_sum_x = (trk_sum_x + (int'(b.x) - xl)) & SUM_MASK;
            trk_sum_y = (trk_sum_y + (int'(b.y) - yl)) & SUM_MASK;
        end
        if (!b.last)
            return;
        if (trk_count == 0)
        begin
            trk_active = 1'b0;
        end
        else
        begin
            trk_cx = centroid_coord(xl, trk_sum_x, trk_count);
            trk_cy = centroid_coord(yl, trk_sum_y, trk_count);
        end
        res.tracking = trk_active;
        res.cx       = 14'(trk_cx);
        res.cy       = 14'(trk_cy);
        res.weight   = 21'(trk_count);
        centroid_q.insert(centroid_q.size(), res);
        results_expected++;
        trk_count = 0;
        trk_sum_x = 0;
        trk_sum_y = 0;
    endtask

    function automatic pixel_beat_t pixel_at(input int x, input int y, input int h,
                                             input int s, input int v, input bit last);
        pixel_beat_t b;
        b.op   = OP_PIXEL;
        b.x    = 10'(x);
        b.y    = 10'(y);
        b.hue  = 8'(h);
        b.sat  = 8'(s);
        b.val  = 8'(v);
        b.last = last;
        return b;
    endfunction

    function automatic pixel_beat_t load_beat(input int x, input int y);
        pixel_beat_t b;
        b    = pixel_at(x, y, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                        1'($urandom_range(1)));
        b.op = OP_LOAD;
        return b;
    endfunction

    // Start centres lean toward the image corners
    function automatic int start_coord();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 0;
        else if (r == 1)
            return 1023;
        return $urandom_range(1023);
    endfunction

    function automatic int window_span();
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return 0;
        else if (r < 75)
            return $urandom_range(64, 1);
        return $urandom_range(1024, 1);
    endfunction

    // Mostly in-window colour matches, some in-window misses, some noise
    function automatic pixel_beat_t frame_pixel(input bit last);
        int xl, xh, yl, yh, r, lo, hi, off;
        pixel_beat_t b;
        axis_window(trk_cx, reg_file[CFG_WIN_WIDTH], IMG_W, xl, xh);
        axis_window(trk_cy, reg_file[CFG_WIN_HEIGHT], IMG_H, yl, yh);
        if (xh > IMG_W)
            xh = IMG_W;
        if (yh > IMG_H)
            yh = IMG_H;
        r = $urandom_range(99);
        b = pixel_at($urandom_range(1023), $urandom_range(1023), $urandom_range(255),
                     $urandom_range(255), $urandom_range(255), last);
        if (r < 85 && xl < xh && yl < yh)
        begin
            b.x = 10'($urandom_range(xh - 1, xl));
            b.y = 10'($urandom_range(yh - 1, yl));
        end
        if (r < 75)
        begin
            off   = $urandom_range(reg_file[CFG_HUE_TOLERANCE]);
            off   = $urandom_range(1) ? off : HUE_R - off;
            b.hue = 8'((reg_file[CFG_TARGET_HUE] + off) % HUE_R);
            lo    = reg_file[CFG_SAT_LOW];
            hi    = reg_file[CFG_SAT_HIGH];
            if (lo <= hi)
                b.sat = 8'($urandom_range(hi, lo));
            lo = reg_file[CFG_VAL_LOW];
            hi = reg_file[CFG_VAL_HIGH];
            if (lo <= hi)
                b.val = 8'($urandom_range(hi, lo));
        end
        // broken sequences: stray load or early frame end
        if (r >= 98)
            b.op = OP_LOAD;
        else if (r == 97)
            b.last = 1'b1;
        return b;
    endfunction

    // Offer one beat, hold it until accepted, then predict
    task automatic send_beat(input pixel_beat_t b);
        int gap;
        gap = tx_idling ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.op;
        s_tlast  <= b.last;
        s_tdata  <= {4'b0, b.val, b.sat, b.hue, b.y, b.x};
        do
            @(posedge clk);
        while (!s_tready);
        update_centroid(b);
    endtask

    // Drop valid and wait for every pending result plus the frame-end latency
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (centroid_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input int tgt, input int tol, input int sl, input int sh,
                                  input int vl, input int vh, input int w, input int h);
        int v [8];
        wait_idle();
        v[CFG_TARGET_HUE]    = tgt;
        v[CFG_HUE_TOLERANCE] = tol;
        v[CFG_SAT_LOW]       = sl;
        v[CFG_SAT_HIGH]      = sh;
        v[CFG_VAL_LOW]       = vl;
        v[CFG_VAL_HIGH]      = vh;
        v[CFG_WIN_WIDTH]     = w;
        v[CFG_WIN_HEIGHT]    = h;
        for (int i = 0; i < 8; i++)
        begin
            cfg_we      <= 1'b1;
            cfg_index   <= CFG_IDX_W'(i);
            cfg_data    <= CFG_W'(v[i]);
            reg_file[i] = v[i] & ((1 << reg_width[i]) - 1);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_frames(input int n);
        int len;
        repeat (n)
        begin
            if (!trk_active || $urandom_range(4) == 0)
                send_beat(load_beat(start_coord(), start_coord()));
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
            for (int i = 0; i < len; i++)
                send_beat(frame_pixel(i == len - 1));
        end
    endtask

    // Pixels and frame ends before any load give nothing
    task automatic test_untracked();
        send_beat(pixel_at(10, 10, 0, 0, 0, 1'b0));
        send_beat(pixel_at(10, 10, 0, 0, 0, 1'b1));
        send_beat(pixel_at(1023, 1023, 255, 255, 255, 1'b1));
    endtask

    task automatic test_directed();
        // top-left corner: window clamps at zero, hue wraps, out-of-range hue
        send_beat(load_beat(0, 0));
        send_beat(pixel_at(0, 0, 0, 0, 0, 1'b0));
        send_beat(pixel_at(15, 15, 170, 255, 255, 1'b0));
        send_beat(pixel_at(16, 0, 0, 128, 128, 1'b0));
        send_beat(pixel_at(3, 4, 255, 128, 128, 1'b0));
        send_beat(pixel_at(5, 5, 11, 128, 128, 1'b1));
        // bottom-right corner: far edge clamps to the last pixel
        send_beat(load_beat(1023, 1023));
        send_beat(pixel_at(1023, 1023, 0, 9, 9, 1'b0));
        send_beat(pixel_at(1022, 1007, 10, 9, 9, 1'b1));
        // saturation low above high: nothing matches, tracking drops
        apply_settings(0, 10, 200, 100, 0, 255, 32, 32);
        send_beat(load_beat(500, 500));
        send_beat(pixel_at(500, 500, 0, 150, 150, 1'b1));
        send_beat(pixel_at(500, 500, 0, 150, 150, 1'b0));
        send_beat(pixel_at(501, 500, 0, 0, 0, 1'b1));
        // zero window width: empty window
        apply_settings(0, 10, 0, 255, 0, 255, 0, 32);
        send_beat(load_beat(100, 100));
        send_beat(pixel_at(100, 100, 0, 0, 0, 1'b1));
        // value bounds, exact hue with zero tolerance
        apply_settings(90, 0, 0, 255, 10, 20, 32, 32);
        send_beat(load_beat(200, 300));
        send_beat(pixel_at(200, 300, 90, 0, 9, 1'b0));
        send_beat(pixel_at(201, 301, 90, 0, 21, 1'b0));
        send_beat(pixel_at(202, 302, 90, 0, 10, 1'b0));
        send_beat(pixel_at(203, 303, 90, 0, 20, 1'b1));
    endtask

    // Register extremes, each followed by a few tracked frames
    task automatic test_register_settings();
        apply_settings(0, 0, 0, 255, 0, 255, 1, 1);
        run_frames(3);
        apply_settings(179, 90, 255, 255, 0, 0, 1024, 1024);
        run_frames(2);
        apply_settings(90, 45, 100, 200, 50, 150, 2047, 7);
        run_frames(2);
        apply_settings(5, 12, 0, 255, 0, 255, 16, 16);
        run_frames(3);
        apply_settings(0, 10, 0, 255, 0, 255, 32, 32);
        run_frames(2);
    endtask

    // Hold the output off long enough that the input stalls behind a frame end
    task automatic test_backpressure();
        tx_idling   = 1'b0;
        rx_hold_req = PRESSURE_HOLD;
        send_beat(load_beat(512, 512));
        repeat (4)
        begin
            for (int i = 0; i < 8; i++)
                send_beat(frame_pixel(i == 7));
        end
        tx_idling = 1'b1;
    endtask

    task automatic test_random();
        int start_beats, start_results, frame_no;
        start_beats   = beats_used;
        start_results = results_expected;
        frame_no      = 0;
        while (beats_used - start_beats < RANDOM_ITEMS ||
               results_expected - start_results < RANDOM_RESULTS)
        begin
            // fresh random settings now and then, low above high only rarely
            if (frame_no % 12 == 11)
            begin
                int s0, s1, v0, v1;
                s0 = $urandom_range(255);
                s1 = $urandom_range(255);
                v0 = $urandom_range(255);
                v1 = $urandom_range(255);
                if ((s0 > s1) != ($urandom_range(9) == 0))
                    {s0, s1} = {s1, s0};
                if (v0 > v1)
                    {v0, v1} = {v1, v0};
                apply_settings($urandom_range(179), $urandom_range(90), s0, s1, v0, v1,
                               window_span(), window_span());
            end
            tx_idling = ($urandom_range(3) != 0);
            rx_idling = ($urandom_range(3) != 0);
            run_frames(1);
            frame_no++;
        end
        tx_idling = 1'b1;
        rx_idling = 1'b1;
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch on result %0d: %s", results_seen, msg);
    endtask

    // Receiver: random stalls plus the long hold requested by the pressure test
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_hold_req > 0)
            begin
                rx_stall    = rx_hold_req;
                rx_hold_req = 0;
            end
            else if (rx_stall == 0 && rx_idling)
            begin
                rx_stall = pick_gap();
            end
            if (rx_stall > 0)
            begin
                m_tready <= 1'b0;
                rx_stall--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result beat with the oldest predicted centroid
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got_c.tracking = m_tuser;
            got_c.cx       = m_tdata[13:0];
            got_c.cy       = m_tdata[27:14];
            got_c.weight   = m_tdata[48:28];
            if (!got_c.tracking)
                results_lost++;
            if (centroid_q.size() == 0)
            begin
                report_mismatch("result beat with no centroid expected");
            end
            else
            begin
                want_c = centroid_q.pop_front();
                if (got_c.tracking !== want_c.tracking)
                    report_mismatch($sformatf("tracking got %0d, expected %0d",
                                              got_c.tracking, want_c.tracking));
                if (got_c.cx !== want_c.cx)
                    report_mismatch($sformatf("centre_x got %0d, expected %0d",
                                              got_c.cx, want_c.cx));
                if (got_c.cy !== want_c.cy)
                    report_mismatch($sformatf("centre_y got %0d, expected %0d",
                                              got_c.cy, want_c.cy));
                if (got_c.weight !== want_c.weight)
                    report_mismatch($sformatf("weight got %0d, expected %0d",
                                              got_c.weight, want_c.weight));
            end
        end
    end

    // Watchdog: end the run after too long without any beat or write
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles, %0d centroids pending",
                     idle_cycles, centroid_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_untracked();
        test_directed();
        test_register_settings();
        test_backpressure();
        test_random();
        wait_idle();

        $display("%0d tracked beats (%0d loads), %0d centroid results, %0d with tracking lost",
                 beats_used, loads_sent, results_seen, results_lost);
        $display("covered register extremes, edge clamping, hue wrap and a %0d-cycle output hold",
                 PRESSURE_HOLD);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/hsvwct_pkg.sv
src/hsvwct_ctrl.sv
src/hsvwct_window.sv
src/hsvwct_datapath.sv
src/hsv_window_centroid_tracker_top.sv
test/tb_hsv_window_centroid_tracker_top.sv
